[hw/rtl/gffp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffp_pkg
// Shared types and constants of the grid first-fit placer.
// ----------------------------------------------------------------------------
package gffp_pkg;

    localparam int MAX_COLS_DEF = 16;
    localparam int MAX_ROWS_DEF = 64;

    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_BAD_SPAN = 2'd1;
    localparam logic [1:0] ST_NO_ROOM  = 2'd2;

    localparam logic [4:0] COLUMN_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [4:0] column_count;
    } cfg_t;

    typedef struct packed {
        logic [4:0] col_span;
        logic [6:0] row_span;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] place_column;
        logic [5:0] place_row;
        logic [6:0] rows_in_use;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic step;
    } fit_ctl_t;

endpackage

[hw/rtl/gffp_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffp_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface gffp_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input ready, input payload);
endinterface

[hw/rtl/gffp_occ_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffp_occ_ram
// Occupancy bitmap, one row per word, one write and one registered read port.
// ----------------------------------------------------------------------------
module gffp_occ_ram #(
    parameter int DEPTH  = gffp_pkg::MAX_ROWS_DEF,
    parameter int WIDTH  = gffp_pkg::MAX_COLS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/gffp_fit_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffp_fit_unit
// Per-column free-run counters and first-fit column search, one row a step.
// ----------------------------------------------------------------------------
module gffp_fit_unit #(
    parameter int MAX_COLS = gffp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = gffp_pkg::MAX_ROWS_DEF,
    parameter int CIDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    parameter int CNT_W    = ($clog2(MAX_COLS + 1) > 5) ? $clog2(MAX_COLS + 1) : 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gffp_pkg::fit_ctl_t ctl,
    input  logic [MAX_COLS-1:0] row_bits,
    input  logic [4:0]         col_span,
    input  logic [6:0]         row_span,
    input  logic [CNT_W-1:0]   cols,
    output logic               found,
    output logic [CIDX_W-1:0]  hit_col,
    output logic [MAX_COLS-1:0] hit_mask
);

    localparam int RUN_W = $clog2(MAX_ROWS + 1);
    localparam int RSW   = (RUN_W > 7) ? RUN_W : 7;

    logic [RUN_W-1:0]    run_reg  [MAX_COLS];
    logic [RUN_W-1:0]    run_next [MAX_COLS];
    logic [MAX_COLS-1:0] bad;
    logic [MAX_COLS-1:0] smask;
    logic [MAX_COLS-1:0] fit;

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            run_next[c] = row_bits[c] ? '0 : run_reg[c] + RUN_W'(1);
            bad[c]      = RSW'(run_next[c]) < RSW'(row_span);
            smask[c]    = CNT_W'(c) < CNT_W'(col_span);
        end
    end

    always_comb
    begin
        for (int x = 0; x < MAX_COLS; x++)
        begin
            fit[x] = (((smask << x) & bad) == '0)
                  && ((CNT_W + 1)'(x) + (CNT_W + 1)'(col_span) <= (CNT_W + 1)'(cols));
        end
    end

    always_comb
    begin
        hit_col = '0;
        for (int x = MAX_COLS - 1; x >= 0; x--)
        begin
            if (fit[x])
            begin
                hit_col = CIDX_W'(x);
            end
        end
    end

    assign found    = ctl.step && (fit != '0);
    assign hit_mask = smask << hit_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                run_reg[c] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                run_reg[c] <= '0;
            end
        end
        else if (ctl.step)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                run_reg[c] <= run_next[c];
            end
        end
    end

endmodule

[hw/rtl/grid_first_fit_placer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_first_fit_placer
// First-fit placement of rectangles on a row-bounded grid of occupancy bits.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  cfg      in   column_count                                     valid/ready
//  req      in   col_span, row_span                               valid/ready
//  rsp      out  status, place_column, place_row, rows_in_use     valid/ready
//
//  a rejected item goes from IDLE through FIN to the result register
//  a placed item scans rows from row 0 to its bottom row, then writes its rows
//  from top to bottom; without a fit every row is scanned; the occupancy ram delivers one row a cycle
//  reset clears the row count and sets column_count to 16; rows past the
//  row count read as free, so the ram needs no clearing pass
//  a result waits in the output register while the next item is accepted
// ----------------------------------------------------------------------------
module grid_first_fit_placer #(
    parameter int MAX_COLS = gffp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = gffp_pkg::MAX_ROWS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    gffp_chan_if.sink   cfg,
    gffp_chan_if.sink   req,
    gffp_chan_if.source rsp
);

    localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CNT_W  = ($clog2(MAX_COLS + 1) > 5) ? $clog2(MAX_COLS + 1) : 5;
    localparam int RSW    = (RCNT_W > 7) ? RCNT_W : 7;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam logic [RIDX_W-1:0] LAST_ROW = RIDX_W'(MAX_ROWS - 1);

    logic [1:0]          state_reg, state_next;
    logic [RIDX_W-1:0]   row_reg, row_next;
    logic [RIDX_W-1:0]   bot_reg, bot_next;
    logic [RIDX_W-1:0]   py_reg, py_next;
    logic [CIDX_W-1:0]   pc_reg, pc_next;
    logic [1:0]          status_reg, status_next;
    logic [MAX_COLS-1:0] mask_reg, mask_next;
    logic [4:0]          cspan_reg, cspan_next;
    logic [6:0]          rspan_reg, rspan_next;
    logic [RCNT_W-1:0]   row_count_reg, row_count_next;
    logic [4:0]          column_count_reg, column_count_next;
    logic                out_vld_reg, out_vld_next;
    gffp_pkg::rsp_t      out_reg, out_next;

    logic                rd_en;
    logic [RIDX_W-1:0]   rd_addr;
    logic [MAX_COLS-1:0] rd_data;
    logic                wr_en;
    logic [MAX_COLS-1:0] wr_data;
    logic [MAX_COLS-1:0] row_bits;

    gffp_pkg::fit_ctl_t  fit_ctl;
    logic                fit_found;
    logic [CIDX_W-1:0]   fit_col;
    logic [MAX_COLS-1:0] fit_mask;

    logic [CNT_W-1:0]    cols;
    logic [RSW-1:0]      top_row;
    logic                req_bad;

    gffp_occ_ram #(
        .DEPTH  (MAX_ROWS),
        .WIDTH  (MAX_COLS),
        .ADDR_W (RIDX_W)
    ) u_occ_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gffp_fit_unit #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CIDX_W   (CIDX_W),
        .CNT_W    (CNT_W)
    ) u_fit_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (fit_ctl),
        .row_bits (row_bits),
        .col_span (cspan_reg),
        .row_span (rspan_reg),
        .cols     (cols),
        .found    (fit_found),
        .hit_col  (fit_col),
        .hit_mask (fit_mask)
    );

    // rows at or past the row count are free whatever the ram holds
    assign row_bits = (RCNT_W'(row_reg) < row_count_reg) ? rd_data : '0;
    assign wr_data  = row_bits | mask_reg;

    assign cols = (CNT_W'(column_count_reg) > CNT_W'(MAX_COLS))
                ? CNT_W'(MAX_COLS) : CNT_W'(column_count_reg);

    assign req_bad = (req.payload.col_span == 5'd0) || (req.payload.row_span == 7'd0)
                  || (CNT_W'(req.payload.col_span) > cols);

    assign top_row = RSW'(row_reg) + RSW'(1) - RSW'(rspan_reg);

    assign cfg.ready   = 1'b1;
    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = out_reg;

    always_comb
    begin
        state_next        = state_reg;
        row_next          = row_reg;
        bot_next          = bot_reg;
        py_next           = py_reg;
        pc_next           = pc_reg;
        status_next       = status_reg;
        mask_next         = mask_reg;
        cspan_next        = cspan_reg;
        rspan_next        = rspan_reg;
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        out_vld_next      = out_vld_reg && !rsp.ready;
        out_next          = out_reg;
        rd_en             = 1'b0;
        rd_addr           = row_reg;
        wr_en             = 1'b0;
        fit_ctl           = '0;

        if (cfg.valid)
        begin
            column_count_next = cfg.payload.column_count;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cspan_next = req.payload.col_span;
                    rspan_next = req.payload.row_span;
                    pc_next    = '0;
                    py_next    = '0;
                    if (req_bad)
                    begin
                        status_next = gffp_pkg::ST_BAD_SPAN;
                        state_next  = S_FIN;
                    end
                    else if (RSW'(req.payload.row_span) > RSW'(MAX_ROWS))
                    begin
                        status_next = gffp_pkg::ST_NO_ROOM;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        fit_ctl.clear = 1'b1;
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        row_next      = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                fit_ctl.step = 1'b1;
                if (fit_found)
                begin
                    pc_next     = fit_col;
                    mask_next   = fit_mask;
                    py_next     = RIDX_W'(top_row);
                    bot_next    = row_reg;
                    row_next    = RIDX_W'(top_row);
                    rd_en       = 1'b1;
                    rd_addr     = RIDX_W'(top_row);
                    status_next = gffp_pkg::ST_PLACED;
                    state_next  = S_WRITE;
                end
                else if (row_reg == LAST_ROW)
                begin
                    status_next = gffp_pkg::ST_NO_ROOM;
                    state_next  = S_FIN;
                end
                else
                begin
                    row_next = row_reg + RIDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = row_reg + RIDX_W'(1);
                end
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
                if (row_reg == bot_reg)
                begin
                    if (RCNT_W'(bot_reg) + RCNT_W'(1) > row_count_reg)
                    begin
                        row_count_next = RCNT_W'(bot_reg) + RCNT_W'(1);
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    row_next = row_reg + RIDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = row_reg + RIDX_W'(1);
                end
            end
            S_FIN:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next          = 1'b1;
                    out_next.status       = status_reg;
                    out_next.place_column = 4'(pc_reg);
                    out_next.place_row    = 6'(py_reg);
                    out_next.rows_in_use  = 7'(row_count_reg);
                    state_next            = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_count_reg    <= '0;
            column_count_reg <= gffp_pkg::COLUMN_COUNT_RESET;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            out_vld_reg      <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        bot_reg    <= bot_next;
        py_reg     <= py_next;
        pc_reg     <= pc_next;
        status_reg <= status_next;
        mask_reg   <= mask_next;
        cspan_reg  <= cspan_next;
        rspan_reg  <= rspan_next;
        out_reg    <= out_next;
    end

endmodule

[hw/rtl/gffp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffp_checker
// Port-level checks of the grid first-fit placer, bound to the top level.
// ----------------------------------------------------------------------------
module gffp_checker #(
    parameter int MAX_ROWS = gffp_pkg::MAX_ROWS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input gffp_pkg::rsp_t rsp_payload
);

    logic [6:0] last_rows_reg;
    logic       rsp_take;

    assign rsp_take = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rows_reg <= '0;
        end
        else if (rsp_take)
        begin
            last_rows_reg <= rsp_payload.rows_in_use;
        end
    end

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result dropped or changed while stalled");

    // the block is not ready in the cycle after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("item accepted while a placement is in progress");

    // unplaced results carry a zero position
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.status != gffp_pkg::ST_PLACED
        |-> rsp_payload.place_column == 4'd0 && rsp_payload.place_row == 6'd0)
    else $error("nonzero position on an unplaced result");

    // the row count never shrinks
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take |-> (MAX_ROWS > 127) || rsp_payload.rows_in_use >= last_rows_reg)
    else $error("rows in use went down");

    // a placed rectangle lies within the rows in use
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.status == gffp_pkg::ST_PLACED
        |-> (MAX_ROWS > 64) || 7'(rsp_payload.place_row) < rsp_payload.rows_in_use)
    else $error("placed row beyond rows in use");

endmodule

bind grid_first_fit_placer gffp_checker #(
    .MAX_ROWS (MAX_ROWS)
) u_gffp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
